>>> rtl/hbfn_pkg.sv
// Package for the HOG block feature normalizer.
// Holds the block geometry, the datapath widths and the norm mode codes.
// It depends on nothing else and is compiled first.
package hbfn_pkg;

	localparam int BINS            = 9;
	localparam int CELLS_PER_BLOCK = 4;
	localparam int BLOCK_LEN       = BINS * CELLS_PER_BLOCK;
	localparam int IDX_W           = $clog2(BLOCK_LEN);
	localparam int CNT_W           = $clog2(BLOCK_LEN + 1);

	localparam int VAL_W   = 32;
	localparam int FRAC_W  = 16;
	localparam int DIVD_W  = VAL_W + FRAC_W;
	localparam int NORM_W  = VAL_W + $clog2(BLOCK_LEN);
	localparam int ACC_W   = 64;
	localparam int ROOT_W  = 32;
	localparam int INDEX_W = 6;
	localparam int MODE_W  = 2;

	localparam logic [VAL_W-1:0] VAL_FULL = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE = 2'd0,
		MODE_MAX  = 2'd1,
		MODE_L1   = 2'd2,
		MODE_L2   = 2'd3
	} norm_mode_t;

endpackage

>>> rtl/hbfn_ifs.sv
// Handshake channel interfaces of the HOG block feature normalizer.
// Holds the corner input, feature output and mode configuration channels.
// Depends on hbfn_pkg for the field widths.
interface hbfn_in_if;
	logic                       valid;
	logic                       ready;
	logic [hbfn_pkg::VAL_W-1:0] corner_top_left;
	logic [hbfn_pkg::VAL_W-1:0] corner_bottom_right;
	logic [hbfn_pkg::VAL_W-1:0] corner_top_right;
	logic [hbfn_pkg::VAL_W-1:0] corner_bottom_left;
	logic                       last_element;

	modport source (
		output valid, corner_top_left, corner_bottom_right, corner_top_right,
		       corner_bottom_left, last_element,
		input  ready
	);
	modport sink (
		input  valid, corner_top_left, corner_bottom_right, corner_top_right,
		       corner_bottom_left, last_element,
		output ready
	);
endinterface

interface hbfn_out_if;
	logic                         valid;
	logic                         ready;
	logic [hbfn_pkg::VAL_W-1:0]   feature_value;
	logic [hbfn_pkg::INDEX_W-1:0] element_index;
	logic                         last_result;

	modport source (output valid, feature_value, element_index, last_result, input ready);
	modport sink (input valid, feature_value, element_index, last_result, output ready);
endinterface

interface hbfn_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [hbfn_pkg::MODE_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/hbfn_bin_ram.sv
// Simple dual-port synchronous RAM that holds the rectangle sums of one block.
// One write port and one read port with registered read data.
// Generic; depends on nothing else.
module hbfn_bin_ram #(
	parameter int DEPTH = 36,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/hbfn_sqrt.sv
// Iterative integer square root of the 64-bit sum of squares, rounded down.
// Resolves one result bit per cycle and pulses done at the end.
// Depends on hbfn_pkg for the widths.
module hbfn_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hbfn_pkg::ACC_W-1:0]  radicand,
	output logic                        done,
	output logic [hbfn_pkg::ROOT_W-1:0] root
);
	import hbfn_pkg::*;

	localparam int STEPS  = ACC_W / 2;
	localparam int STEP_W = $clog2(STEPS);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [ACC_W-1:0]  x_q;
	logic [ACC_W-1:0]  root_q;
	logic [ACC_W-1:0]  bit_q;
	logic [ACC_W-1:0]  trial;
	logic              take;

	assign trial = root_q + bit_q;
	assign take  = x_q >= trial;
	assign root  = root_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			bit_q  <= ACC_W'(1) << (ACC_W - 2);
		end else if (busy_q) begin
			if (take) begin
				x_q    <= x_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

>>> rtl/hbfn_div.sv
// Restoring divider for the Q16.16 scaling of one element by the block norm.
// Produces one quotient bit per cycle and pulses done after the last bit.
// Depends on hbfn_pkg for the widths.
module hbfn_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hbfn_pkg::DIVD_W-1:0] dividend,
	input  logic [hbfn_pkg::NORM_W-1:0] divisor,
	output logic                        done,
	output logic [hbfn_pkg::DIVD_W-1:0] quotient
);
	import hbfn_pkg::*;

	localparam int STEP_W = $clog2(DIVD_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [NORM_W-1:0] div_q;
	logic [NORM_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [NORM_W:0]   rem_shift;
	logic [NORM_W:0]   rem_diff;
	logic              ge;

	assign rem_shift = {rem_q, quo_q[DIVD_W-1]};
	assign rem_diff  = rem_shift - {1'b0, div_q};
	assign ge        = rem_shift >= {1'b0, div_q};
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_diff[NORM_W-1:0] : rem_shift[NORM_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

endmodule

>>> rtl/hog_block_feature_normalizer.sv
// HOG block feature normalizer: each corner transaction stores one rectangle sum in the
// bin RAM while it holds fewer than BLOCK_LEN sums. A transaction marked last starts a
// norm pass over the RAM, then the bit-serial square root in L2 mode; mode none skips
// the norm pass. Each element is then emitted from the RAM in mode none, as zero with a
// zero norm, else via the one-bit-per-cycle divider; held until the output is ready.
// Depends on hbfn_pkg, hbfn_ifs, hbfn_bin_ram, hbfn_sqrt and hbfn_div.
module hog_block_feature_normalizer (
	input  logic       clk,
	input  logic       arst_n,
	hbfn_cfg_if.sink   mode_cfg,
	hbfn_in_if.sink    corners,
	hbfn_out_if.source features
);
	import hbfn_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_NORM,
		ST_ROOT,
		ST_EMIT_RD,
		ST_EMIT_DATA,
		ST_EMIT_DIV,
		ST_EMIT_OUT
	} state_t;

	state_t            state_q;
	norm_mode_t        norm_mode_q;
	norm_mode_t        blk_mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  issue_q;
	logic [CNT_W-1:0]  emit_q;
	logic [VAL_W:0]    pos_q;
	logic [VAL_W:0]    neg_q;
	logic              last_q;
	logic [ACC_W-1:0]  acc_q;
	logic [NORM_W-1:0] norm_q;
	logic              out_vld_q;
	logic [VAL_W-1:0]  feat_q;
	logic [INDEX_W-1:0] index_q;
	logic              flag_q;

	logic              rd_vld_s1;
	logic              vld_s2;
	logic [ACC_W-1:0]  val_s2;

	logic [VAL_W:0]    diff;
	logic [VAL_W-1:0]  rect_sum;
	logic              ram_we;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;
	logic              norm_rd;
	logic              norm_done;
	logic [ACC_W:0]    acc_sum;
	logic              sqrt_start;
	logic              sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic              div_start;
	logic              div_done;
	logic [DIVD_W-1:0] div_quo;
	logic [VAL_W-1:0]  div_sat;
	logic              emit_last;

	assign mode_cfg.ready = 1'b1;
	assign corners.ready  = (state_q == ST_IDLE);

	assign features.valid         = out_vld_q;
	assign features.feature_value = feat_q;
	assign features.element_index = index_q;
	assign features.last_result   = flag_q;

	assign diff     = pos_q - neg_q;
	assign rect_sum = (pos_q <= neg_q) ? '0 : (diff[VAL_W] ? VAL_FULL : diff[VAL_W-1:0]);

	assign ram_we    = (state_q == ST_LOAD) && (count_q < CNT_W'(BLOCK_LEN));
	assign norm_rd   = (state_q == ST_NORM) && (issue_q < count_q);
	assign ram_re    = norm_rd || (state_q == ST_EMIT_RD);
	assign ram_raddr = (state_q == ST_NORM) ? issue_q[IDX_W-1:0] : emit_q[IDX_W-1:0];
	assign norm_done = (state_q == ST_NORM) && (issue_q == count_q) && !rd_vld_s1 && !vld_s2;

	assign acc_sum    = {1'b0, acc_q} + {1'b0, val_s2};
	assign sqrt_start = norm_done && (blk_mode_q == MODE_L2);
	assign div_start  = (state_q == ST_EMIT_DATA) && (blk_mode_q != MODE_NONE) && (norm_q != '0);
	assign div_sat    = (div_quo[DIVD_W-1:VAL_W] != '0) ? VAL_FULL : div_quo[VAL_W-1:0];
	assign emit_last  = (emit_q == count_q - CNT_W'(1));

	hbfn_bin_ram #(
		.DEPTH (BLOCK_LEN),
		.WIDTH (VAL_W)
	) u_bin_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (rect_sum),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	hbfn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	hbfn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({ram_rdata, FRAC_W'(0)}),
		.divisor  (norm_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_mode_q <= MODE_L2;
		end else if (mode_cfg.valid) begin
			norm_mode_q <= norm_mode_t'(mode_cfg.data);
		end
	end

	always_ff @(posedge clk) begin
		if (corners.valid && corners.ready) begin
			pos_q  <= {1'b0, corners.corner_top_left} + {1'b0, corners.corner_bottom_right};
			neg_q  <= {1'b0, corners.corner_top_right} + {1'b0, corners.corner_bottom_left};
			last_q <= corners.last_element;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			rd_vld_s1 <= norm_rd;
			vld_s2    <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			val_s2 <= (blk_mode_q == MODE_L2) ? ACC_W'(ram_rdata * ram_rdata)
			                                  : ACC_W'(ram_rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			blk_mode_q <= MODE_L2;
			count_q    <= '0;
			issue_q    <= '0;
			emit_q     <= '0;
			acc_q      <= '0;
			norm_q     <= '0;
			out_vld_q  <= 1'b0;
			feat_q     <= '0;
			index_q    <= '0;
			flag_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (corners.valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (ram_we) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (last_q) begin
						blk_mode_q <= norm_mode_q;
						issue_q    <= '0;
						emit_q     <= '0;
						acc_q      <= '0;
						norm_q     <= '0;
						state_q    <= (norm_mode_q == MODE_NONE) ? ST_EMIT_RD : ST_NORM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_NORM: begin
					if (norm_rd) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (vld_s2) begin
						case (blk_mode_q)
							MODE_MAX: begin
								if (val_s2 > acc_q) begin
									acc_q <= val_s2;
								end
							end
							MODE_L2: begin
								acc_q <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
							end
							default: begin
								acc_q <= acc_sum[ACC_W-1:0];
							end
						endcase
					end
					if (norm_done) begin
						if (blk_mode_q == MODE_L2) begin
							state_q <= ST_ROOT;
						end else begin
							norm_q  <= acc_q[NORM_W-1:0];
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						norm_q  <= NORM_W'(sqrt_root);
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_DATA;
				end
				ST_EMIT_DATA: begin
					index_q <= INDEX_W'(emit_q);
					flag_q  <= emit_last;
					if (blk_mode_q == MODE_NONE) begin
						feat_q    <= ram_rdata;
						out_vld_q <= 1'b1;
						state_q   <= ST_EMIT_OUT;
					end else if (norm_q == '0) begin
						feat_q    <= '0;
						out_vld_q <= 1'b1;
						state_q   <= ST_EMIT_OUT;
					end else begin
						state_q <= ST_EMIT_DIV;
					end
				end
				ST_EMIT_DIV: begin
					if (div_done) begin
						feat_q    <= div_sat;
						out_vld_q <= 1'b1;
						state_q   <= ST_EMIT_OUT;
					end
				end
				ST_EMIT_OUT: begin
					if (features.ready) begin
						out_vld_q <= 1'b0;
						if (flag_q) begin
							count_q <= '0;
							acc_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							emit_q  <= emit_q + CNT_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/sv/tb_hog_block_feature_normalizer.sv
// Self-checking testbench for hog_block_feature_normalizer: random and directed corner blocks
// in every norm mode, with sender bursts, receiver stalls and a long output hold-off.
// Depends on hbfn_pkg, hbfn_ifs and the normalizer RTL with its submodules.
module tb_hog_block_feature_normalizer;
	import hbfn_pkg::*;

	localparam int QUIET_LIMIT    = 4000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int TOTAL_ITEMS    = 310;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_style_t;

	typedef struct {
		logic [VAL_W-1:0] top_left;
		logic [VAL_W-1:0] bottom_right;
		logic [VAL_W-1:0] top_right;
		logic [VAL_W-1:0] bottom_left;
		logic             last;
	} corner_item_t;

	typedef struct {
		logic [VAL_W-1:0]   value;
		logic [INDEX_W-1:0] index;
		logic               last;
	} feature_t;

	logic clk = 1'b0;
	logic arst_n;

	hbfn_cfg_if mode_cfg ();
	hbfn_in_if  corners ();
	hbfn_out_if features ();

	corner_item_t pending_items[$];
	corner_item_t offered_item;
	feature_t     expected_features[$];

	logic [VAL_W-1:0] bin_sums [BLOCK_LEN];
	int               stored_count;
	norm_mode_t       active_mode;

	int        items_queued;
	int        items_accepted;
	int        mismatches;
	bit        sender_bursts;
	rx_style_t receiver_style;
	int        holdoff_requests;
	int        holdoffs_taken;
	int        holdoff_left;
	int        burst_left;
	int        gap_left;
	int        stall_phase;
	int        quiet_cycles;

	hog_block_feature_normalizer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode_cfg(mode_cfg),
		.corners (corners),
		.features(features)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [VAL_W-1:0] rectangle_sum(corner_item_t c);
		logic [VAL_W:0] gain;
		logic [VAL_W:0] loss;
		logic [VAL_W:0] diff;
		gain = {1'b0, c.top_left} + {1'b0, c.bottom_right};
		loss = {1'b0, c.top_right} + {1'b0, c.bottom_left};
		if (gain <= loss)
			return '0;
		diff = gain - loss;
		return diff[VAL_W] ? VAL_FULL : diff[VAL_W-1:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] probe;
		root = '0;
		probe = 64'd1 << 62;
		while (probe > x)
			probe >>= 2;
		while (probe != 0) begin
			if (x >= root + probe) begin
				x -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// Stores the rectangle sum and, on the last element, predicts the whole feature vector.
	task automatic absorb_corners(corner_item_t c);
		logic [63:0] acc;
		logic [63:0] norm;
		logic [63:0] term;
		logic [63:0] scaled;
		feature_t    f;
		if (stored_count < BLOCK_LEN) begin
			bin_sums[stored_count] = rectangle_sum(c);
			stored_count++;
		end
		if (!c.last)
			return;
		acc = '0;
		for (int i = 0; i < stored_count; i++) begin
			term = 64'(bin_sums[i]);
			case (active_mode)
				MODE_MAX: begin
					if (term > acc)
						acc = term;
				end
				MODE_L1: begin
					acc += term;
				end
				MODE_L2: begin
					term = term * term;
					acc = (acc > ~term) ? '1 : acc + term;
				end
				default: begin
				end
			endcase
		end
		norm = (active_mode == MODE_L2) ? floor_sqrt(acc) : acc;
		for (int i = 0; i < stored_count; i++) begin
			if (active_mode == MODE_NONE) begin
				f.value = bin_sums[i];
			end else if (norm == 0) begin
				f.value = '0;
			end else begin
				scaled = (64'(bin_sums[i]) << FRAC_W) / norm;
				f.value = (scaled > 64'(VAL_FULL)) ? VAL_FULL : scaled[VAL_W-1:0];
			end
			f.index = INDEX_W'(i);
			f.last = (i == stored_count - 1);
			expected_features.push_back(f);
		end
		stored_count = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corners.valid <= 1'b0;
			corners.corner_top_left <= '0;
			corners.corner_bottom_right <= '0;
			corners.corner_top_right <= '0;
			corners.corner_bottom_left <= '0;
			corners.last_element <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (corners.valid && corners.ready) begin
				absorb_corners(offered_item);
				items_accepted++;
			end
			if (!corners.valid || corners.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					corners.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					offered_item = pending_items.pop_front();
					corners.valid <= 1'b1;
					corners.corner_top_left <= offered_item.top_left;
					corners.corner_bottom_right <= offered_item.bottom_right;
					corners.corner_top_right <= offered_item.top_right;
					corners.corner_bottom_left <= offered_item.bottom_left;
					corners.last_element <= offered_item.last;
					if (sender_bursts) begin
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(1, 12);
							gap_left = $urandom_range(1, 9);
						end
					end
				end else begin
					corners.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		feature_t want;
		if (!arst_n) begin
			features.ready <= 1'b0;
			holdoff_left = 0;
			stall_phase = 0;
		end else begin
			if (features.valid && features.ready) begin
				if (expected_features.size() == 0) begin
					mismatches++;
					$display("%0t: feature transaction with none expected, actual value %0d index %0d",
						$time, features.feature_value, features.element_index);
				end else begin
					want = expected_features.pop_front();
					if (features.feature_value !== want.value) begin
						mismatches++;
						$display("%0t: feature_value expected %0d actual %0d", $time, want.value,
							features.feature_value);
					end
					if (features.element_index !== want.index) begin
						mismatches++;
						$display("%0t: element_index expected %0d actual %0d", $time, want.index,
							features.element_index);
					end
					if (features.last_result !== want.last) begin
						mismatches++;
						$display("%0t: last_result expected %0d actual %0d", $time, want.last,
							features.last_result);
					end
				end
			end
			if (holdoffs_taken != holdoff_requests) begin
				holdoffs_taken = holdoff_requests;
				holdoff_left = HOLDOFF_CYCLES;
			end
			stall_phase = (stall_phase + 1) % 11;
			if (holdoff_left > 0) begin
				holdoff_left--;
				features.ready <= 1'b0;
			end else begin
				case (receiver_style)
					RX_ALWAYS:  features.ready <= 1'b1;
					RX_RANDOM:  features.ready <= ($urandom_range(0, 3) != 0);
					default:    features.ready <= (stall_phase < 7);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (corners.valid && corners.ready) || (features.valid && features.ready)
				|| (mode_cfg.valid && mode_cfg.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic queue_corners(logic [VAL_W-1:0] tl, logic [VAL_W-1:0] br,
			logic [VAL_W-1:0] tr, logic [VAL_W-1:0] bl, logic last);
		corner_item_t c;
		c.top_left = tl;
		c.bottom_right = br;
		c.top_right = tr;
		c.bottom_left = bl;
		c.last = last;
		pending_items.push_back(c);
		items_queued++;
	endtask

	task automatic queue_random_block(int len);
		logic [VAL_W-1:0] dx;
		logic [VAL_W-1:0] dy;
		logic [VAL_W-1:0] tl;
		for (int n = 0; n < len; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					tl = $urandom;
					dx = $urandom_range(0, 5000);
					dy = $urandom_range(0, 5000);
					queue_corners(tl, tl + dx + dy + ($urandom >> $urandom_range(0, 31)),
						tl + dx, tl + dy, n == len - 1);
				end
				6, 7, 8: begin
					queue_corners($urandom, $urandom, $urandom, $urandom, n == len - 1);
				end
				default: begin
					queue_corners($urandom_range(0, 1) ? VAL_FULL : '0,
						$urandom_range(0, 1) ? VAL_FULL : '0,
						$urandom_range(0, 1) ? VAL_FULL : '0,
						$urandom_range(0, 1) ? VAL_FULL : '0, n == len - 1);
				end
			endcase
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (items_accepted != items_queued || expected_features.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_norm_mode(norm_mode_t m);
		@(posedge clk);
		mode_cfg.valid <= 1'b1;
		mode_cfg.data <= m;
		do
			@(posedge clk);
		while (!mode_cfg.ready);
		mode_cfg.valid <= 1'b0;
		active_mode = m;
	endtask

	initial begin
		norm_mode_t mode_plan[8];
		int         phase;
		int         blocks;
		int         len;
		mode_plan = '{MODE_NONE, MODE_L2, MODE_MAX, MODE_L1, MODE_L2, MODE_NONE, MODE_L1,
			MODE_MAX};
		arst_n = 1'b0;
		mode_cfg.valid = 1'b0;
		mode_cfg.data = MODE_L2;
		corners.valid = 1'b0;
		corners.corner_top_left = '0;
		corners.corner_bottom_right = '0;
		corners.corner_top_right = '0;
		corners.corner_bottom_left = '0;
		corners.last_element = 1'b0;
		features.ready = 1'b0;
		stored_count = 0;
		active_mode = MODE_L2;
		items_queued = 0;
		items_accepted = 0;
		mismatches = 0;
		sender_bursts = 1'b0;
		receiver_style = RX_ALWAYS;
		holdoff_requests = 0;
		holdoffs_taken = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// The mode after reset is L2: overflowing sums, a negative sum, a saturated square sum.
		queue_corners(VAL_FULL, VAL_FULL, '0, '0, 1'b0);
		queue_corners('0, '0, VAL_FULL, VAL_FULL, 1'b0);
		queue_corners(VAL_FULL, VAL_FULL, '0, '0, 1'b0);
		queue_corners(32'd16, 32'd48, 32'd8, 32'd8, 1'b1);
		wait_idle();
		write_norm_mode(MODE_NONE);
		queue_corners(VAL_FULL, '0, '0, '0, 1'b0);
		queue_corners(32'd5, 32'd100, 32'd20, 32'd30, 1'b0);
		queue_corners('0, '0, '0, '0, 1'b1);
		wait_idle();
		write_norm_mode(MODE_MAX);
		queue_corners('0, VAL_FULL, 32'h8000_0000, '0, 1'b0);
		queue_corners(32'd1, 32'd2, '0, '0, 1'b0);
		queue_corners('0, 32'd1, '0, '0, 1'b1);
		queue_corners('0, '0, '0, '0, 1'b0);
		queue_corners(32'd9, 32'd9, 32'd9, 32'd9, 1'b1);
		wait_idle();
		write_norm_mode(MODE_L1);
		queue_corners(32'd100, 32'd300, 32'd50, 32'd50, 1'b0);
		queue_corners(32'd7, 32'd7, 32'd7, 32'd7, 1'b0);
		queue_corners('0, 32'd1, '0, '0, 1'b1);
		queue_corners(32'd3, 32'd3, 32'd3, 32'd3, 1'b1);
		wait_idle();
		write_norm_mode(MODE_L2);
		queue_corners('0, '0, 32'd5, '0, 1'b1);

		phase = 0;
		while (items_queued < TOTAL_ITEMS) begin
			wait_idle();
			write_norm_mode(phase < 8 ? mode_plan[phase] : norm_mode_t'($urandom_range(0, 3)));
			sender_bursts = (phase != 1) && ($urandom_range(0, 3) != 0);
			receiver_style = (phase == 1) ? RX_ALWAYS : rx_style_t'($urandom_range(0, 2));
			if (phase == 2)
				holdoff_requests++;
			blocks = $urandom_range(2, 4);
			for (int b = 0; b < blocks; b++) begin
				if (phase == 2 && b == 0) begin
					len = BLOCK_LEN;
				end else if (phase == 3 && b == 0) begin
					len = BLOCK_LEN + 3;
				end else begin
					case ($urandom_range(0, 19))
						0, 1, 2:  len = BLOCK_LEN;
						3, 4:     len = $urandom_range(BLOCK_LEN - 6, BLOCK_LEN - 1);
						5:        len = $urandom_range(BLOCK_LEN + 1, BLOCK_LEN + 4);
						default:  len = $urandom_range(1, 12);
					endcase
				end
				queue_random_block(len);
			end
			phase++;
		end
		wait_idle();
		if (mismatches == 0 && expected_features.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
